// ===== rtl/boundary_tag_first_fit_allocator_core_defines.svh =====
// Assertion macros for the boundary tag allocator core.
// Used by boundary_tag_first_fit_allocator_core; expects clk and rst_n in scope.
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define BTFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BTFF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/btffa_pkg.sv =====
// Shared types and constants of the boundary tag allocator core.
// No dependencies.
package btffa_pkg;

  localparam int ADDR_W = 34;
  localparam int TAG_W  = 32;
  localparam int SIZE_W = 21;

  localparam logic [TAG_W-1:0]  TAG_SIZE_MASK = 32'hFFFF_FFF8;
  localparam logic [SIZE_W-1:0] CHUNK_RESET   = 21'd4096;
  localparam logic [ADDR_W-1:0] LIST_START    = 34'd8;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NULL = 2'd1;
  localparam logic [1:0] STATUS_OOM  = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [19:0] request_bytes;
    logic [19:0] block_addr;
  } in_word_t;

  typedef struct packed {
    logic [19:0] result_addr;
    logic [1:0]  status;
  } out_word_t;

endpackage

// ===== rtl/boundary_tag_first_fit_allocator_core.sv =====
// Boundary tag first-fit heap allocator with tag word memory and sequencer.
// Depends on btffa_pkg and boundary_tag_first_fit_allocator_core_defines.svh.
//
//  channel | ports                         | direction
//  in      | in_valid, in_stall, in_word   | request words in
//  out     | out_valid, out_stall, out_word| result words out
//  cfg     | cfg_we, cfg_wdata             | chunk size write
//
// After reset a clearing pass writes every heap word. An allocation scans the block
// headers first fit, then places the block; if no block fits the heap grows, or the
// request ends out of memory after the scan. A free writes the tags and merges with
// free neighbours; an ignored free or a zero size goes straight to the result.
// The tag memory has one port. in_stall holds until the result word is taken.
`include "boundary_tag_first_fit_allocator_core_defines.svh"

module boundary_tag_first_fit_allocator_core #(
  parameter int HEAP_BYTES_LOG2 = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  btffa_pkg::in_word_t   in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output btffa_pkg::out_word_t  out_word,
  input  logic                  cfg_we,
  input  logic [20:0]           cfg_wdata
);
  import btffa_pkg::*;

  localparam int IDX_W = HEAP_BYTES_LOG2 - 2;
  localparam int HEAP_WORDS = 1 << IDX_W;
  localparam int BRK_W = HEAP_BYTES_LOG2 + 1;
  localparam logic [ADDR_W-1:0] HEAP_BYTES = ADDR_W'(1) << HEAP_BYTES_LOG2;
  localparam bit INIT_FITS = (HEAP_BYTES_LOG2 >= 13);
  localparam logic [BRK_W-1:0] BRK_INIT = INIT_FITS ? BRK_W'(4112) : BRK_W'(16);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_A_SCAN, S_A_CHK, S_G_CHK, S_G_W1, S_G_W2, S_G_W3,
    S_M_R1, S_M_R2, S_M_R3, S_M_R4, S_M_CALC, S_M_W1, S_M_W2,
    S_P_RD, S_P_W1, S_P_W2, S_P_W3, S_P_W4, S_F_RD, S_F_W1, S_F_W2, S_DONE
  } state_t;

  state_t              state_r;
  logic [IDX_W-1:0]    clr_idx_r;
  logic [BRK_W-1:0]    brk_r;
  logic [SIZE_W-1:0]   chunk_r;
  logic                op_r;
  logic [ADDR_W-1:0]   bp_r, prev_r, next_r, mbase_r;
  logic [SIZE_W-1:0]   asize_r;
  logic [21:0]         gsize_r;
  logic [TAG_W-1:0]    s_r, pw_r, msize_r;
  logic [19:0]         res_r;
  logic [1:0]          status_r;

  logic [TAG_W-1:0]    mem [HEAP_WORDS];
  logic [TAG_W-1:0]    rdata_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_a;
  logic [IDX_W-1:0]    mem_idx;
  logic [TAG_W-1:0]    mem_wd;
  logic [TAG_W-1:0]    init_wd;

  logic [SIZE_W-1:0]   ext;
  logic [21:0]         gsize;
  logic [TAG_W-1:0]    rsize, psize;
  logic [SIZE_W-1:0]   asize_in;
  logic                free_ok;

  always_comb begin
    ext = (asize_r > chunk_r) ? asize_r : chunk_r;
    gsize = {1'b0, ext[20:3], 3'b000} + (ext[2] ? 22'd8 : 22'd0);
    rsize = rdata_r & TAG_SIZE_MASK;
    psize = pw_r & TAG_SIZE_MASK;
    asize_in = (in_word.request_bytes <= 20'd8) ? 21'd16 :
               ((SIZE_W'(in_word.request_bytes) + 21'd15) & ~21'd7);
    free_ok = (in_word.block_addr[2:0] == 3'd0) && (in_word.block_addr >= 20'd16) &&
              (ADDR_W'(in_word.block_addr) < ADDR_W'(brk_r));
  end

  always_comb begin
    init_wd = '0;
    if (clr_idx_r == IDX_W'(1) || clr_idx_r == IDX_W'(2)) begin
      init_wd = 32'd9;
    end else if (clr_idx_r == IDX_W'(3)) begin
      init_wd = INIT_FITS ? 32'd4096 : 32'd1;
    end else if (INIT_FITS && clr_idx_r == IDX_W'(1026)) begin
      init_wd = 32'd4096;
    end else if (INIT_FITS && clr_idx_r == IDX_W'(1027)) begin
      init_wd = 32'd1;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_a  = '0;
    mem_wd = '0;
    case (state_r)
      S_A_SCAN, S_P_RD, S_F_RD, S_M_R2: mem_a = bp_r - ADDR_W'(4);
      S_P_W1: begin
        mem_we = 1'b1;
        mem_a  = bp_r - ADDR_W'(4);
        mem_wd = TAG_W'(asize_r) | 32'd1;
      end
      S_P_W2: begin
        mem_we = 1'b1;
        mem_a  = bp_r + ADDR_W'(asize_r) - ADDR_W'(8);
        mem_wd = TAG_W'(asize_r) | 32'd1;
      end
      S_P_W3: begin
        mem_we = 1'b1;
        mem_a  = bp_r + ADDR_W'(asize_r) - ADDR_W'(4);
        mem_wd = s_r - TAG_W'(asize_r);
      end
      S_P_W4: begin
        mem_we = 1'b1;
        mem_a  = bp_r + ADDR_W'(s_r) - ADDR_W'(8);
        mem_wd = s_r - TAG_W'(asize_r);
      end
      S_G_W1: begin
        mem_we = 1'b1;
        mem_a  = bp_r - ADDR_W'(4);
        mem_wd = TAG_W'(gsize_r);
      end
      S_G_W2: begin
        mem_we = 1'b1;
        mem_a  = bp_r + ADDR_W'(gsize_r) - ADDR_W'(8);
        mem_wd = TAG_W'(gsize_r);
      end
      S_G_W3: begin
        mem_we = 1'b1;
        mem_a  = bp_r + ADDR_W'(gsize_r) - ADDR_W'(4);
        mem_wd = 32'd1;
      end
      S_M_R1: mem_a = bp_r - ADDR_W'(8);
      S_M_R3: mem_a = prev_r - ADDR_W'(4);
      S_M_R4: mem_a = next_r - ADDR_W'(4);
      S_M_W1: begin
        mem_we = 1'b1;
        mem_a  = mbase_r - ADDR_W'(4);
        mem_wd = msize_r;
      end
      S_M_W2: begin
        mem_we = 1'b1;
        mem_a  = mbase_r + ADDR_W'(msize_r) - ADDR_W'(8);
        mem_wd = msize_r;
      end
      S_F_W1: begin
        mem_we = 1'b1;
        mem_a  = bp_r - ADDR_W'(4);
        mem_wd = rsize;
      end
      S_F_W2: begin
        mem_we = 1'b1;
        mem_a  = bp_r + ADDR_W'(s_r) - ADDR_W'(8);
        mem_wd = s_r;
      end
      default: mem_a = '0;
    endcase
    mem_idx = mem_a[HEAP_BYTES_LOG2-1:2];
    if (state_r == S_CLEAR) begin
      mem_we  = 1'b1;
      mem_idx = clr_idx_r;
      mem_wd  = init_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_idx] <= mem_wd;
    end
    rdata_r <= mem[mem_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      brk_r     <= BRK_INIT;
      chunk_r   <= CHUNK_RESET;
    end else begin
      if (cfg_we) begin
        chunk_r <= cfg_wdata;
      end
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + IDX_W'(1);
          if (clr_idx_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_word.kind;
            res_r    <= '0;
            status_r <= STATUS_OK;
            asize_r  <= asize_in;
            if (in_word.kind == KIND_FREE) begin
              bp_r    <= ADDR_W'(in_word.block_addr);
              state_r <= free_ok ? S_F_RD : S_DONE;
            end else if (in_word.request_bytes == 20'd0) begin
              status_r <= STATUS_NULL;
              state_r  <= S_DONE;
            end else begin
              bp_r    <= LIST_START;
              state_r <= S_A_SCAN;
            end
          end
        end
        S_A_SCAN: state_r <= (bp_r >= ADDR_W'(brk_r)) ? S_G_CHK : S_A_CHK;
        S_A_CHK: begin
          if (rsize == '0) begin
            state_r <= S_G_CHK;
          end else if (!rdata_r[0] && rsize >= TAG_W'(asize_r)) begin
            state_r <= S_P_RD;
          end else begin
            bp_r    <= bp_r + ADDR_W'(rsize);
            state_r <= S_A_SCAN;
          end
        end
        S_G_CHK: begin
          if (ADDR_W'(brk_r) + ADDR_W'(gsize) > HEAP_BYTES) begin
            status_r <= STATUS_OOM;
            state_r  <= S_DONE;
          end else begin
            bp_r    <= ADDR_W'(brk_r);
            brk_r   <= brk_r + BRK_W'(gsize);
            gsize_r <= gsize;
            state_r <= S_G_W1;
          end
        end
        S_G_W1: state_r <= S_G_W2;
        S_G_W2: state_r <= S_G_W3;
        S_G_W3: state_r <= S_M_R1;
        S_M_R1: state_r <= S_M_R2;
        S_M_R2: begin
          prev_r  <= bp_r - ADDR_W'(rsize);
          state_r <= S_M_R3;
        end
        S_M_R3: begin
          s_r     <= rsize;
          next_r  <= bp_r + ADDR_W'(rsize);
          state_r <= S_M_R4;
        end
        S_M_R4: begin
          pw_r    <= rdata_r;
          state_r <= S_M_CALC;
        end
        S_M_CALC: begin
          if (pw_r[0] && rdata_r[0]) begin
            state_r <= (op_r == KIND_ALLOC) ? S_P_RD : S_DONE;
          end else if (pw_r[0]) begin
            msize_r <= s_r + rsize;
            mbase_r <= bp_r;
            state_r <= S_M_W1;
          end else begin
            msize_r <= s_r + psize + (rdata_r[0] ? '0 : rsize);
            mbase_r <= prev_r;
            state_r <= S_M_W1;
          end
        end
        S_M_W1: state_r <= S_M_W2;
        S_M_W2: begin
          bp_r    <= mbase_r;
          state_r <= (op_r == KIND_ALLOC) ? S_P_RD : S_DONE;
        end
        S_P_RD: state_r <= S_P_W1;
        S_P_W1: begin
          s_r     <= rsize;
          res_r   <= bp_r[19:0];
          state_r <= S_P_W2;
        end
        S_P_W2: begin
          state_r <= ({1'b0, s_r} >= (33'(asize_r) + 33'd8)) ? S_P_W3 : S_DONE;
        end
        S_P_W3: state_r <= S_P_W4;
        S_P_W4: state_r <= S_DONE;
        S_F_RD: state_r <= S_F_W1;
        S_F_W1: begin
          s_r     <= rsize;
          state_r <= S_F_W2;
        end
        S_F_W2: state_r <= S_M_R1;
        S_DONE: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_word.result_addr = res_r;
  assign out_word.status = status_r;

  `BTFF_ASSERT_IMP(a_out_blocks_in, out_valid, in_stall, "input taken while result pending")
  `BTFF_ASSERT_IMP(a_brk_bound, 1'b1, (brk_r[2:0] == 3'd0) && (ADDR_W'(brk_r) <= HEAP_BYTES), "break out of range")
  `BTFF_ASSERT_NXT(a_brk_grows, 1'b1, brk_r >= $past(brk_r), "break moved down")
  `BTFF_ASSERT_IMP(a_free_status, out_valid && op_r == KIND_FREE, status_r == STATUS_OK && res_r == '0, "free gave nonzero result")

endmodule
